[src/ldwl_pkg.sv]
// shared types and constants for the damped wave leapfrog lattice block
// request codes, register indexes, controller states and the command bundle
// no dependencies
package ldwl_pkg;

	localparam int COORD_W = 5;
	localparam int VAL_W = 32;
	localparam int LAP_W = VAL_W + 4;
	localparam int DIG_W = 32;

	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 64;
	localparam int X_LSB = 0;
	localparam int Y_LSB = X_LSB + COORD_W;
	localparam int Z_LSB = Y_LSB + COORD_W;
	localparam int LF_LSB = Z_LSB + COORD_W;
	localparam int LV_LSB = LF_LSB + VAL_W;

	localparam logic signed [VAL_W-1:0] I32_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] I32_MIN = 32'sh8000_0000;

	localparam logic [1:0] CFG_STEP = 2'd0;
	localparam logic [1:0] CFG_LAP = 2'd1;
	localparam logic [1:0] CFG_DAMP = 2'd2;

	typedef enum logic [1:0] {
		REQ_LOAD,
		REQ_VEL,
		REQ_FIELD,
		REQ_READ
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_CAPTURE,
		ST_GATHER,
		ST_LAPMUL,
		ST_STEPMUL,
		ST_FMUL,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		SEL_C,
		SEL_XP,
		SEL_XM,
		SEL_YP,
		SEL_YM,
		SEL_ZP,
		SEL_ZM
	} rd_sel_t;

	typedef enum logic [2:0] {
		MUL_LAP_LO,
		MUL_LAP_HI,
		MUL_DAMP_V,
		MUL_STEP_LO,
		MUL_STEP_HI,
		MUL_STEP_V
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_HI
	} acc_op_t;

	typedef enum logic [1:0] {
		INNER_NONE,
		INNER_NEG,
		INNER_ADD
	} inner_op_t;

	typedef struct packed {
		logic      latch;
		rd_sel_t   rd_sel;
		logic      lap_init;
		logic      lap_add;
		logic      mul_en;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		inner_op_t inner_op;
		logic      fin;
	} cmd_t;

	typedef struct packed {
		req_t req;
	} status_t;

endpackage

[src/ldwl_ctrl.sv]
// sequencer for the lattice update: memory read order, multiply schedule, result hand-off
// depends on ldwl_pkg
module ldwl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  ldwl_pkg::status_t status,
	output ldwl_pkg::cmd_t   cmd
);
	import ldwl_pkg::*;

	state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.rd_sel = SEL_C;
		cmd.mul_sel = MUL_STEP_V;
		cmd.acc_op = ACC_NONE;
		cmd.inner_op = INNER_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: begin
				cmd.rd_sel = SEL_C;
				state_d = ST_CAPTURE;
			end
			ST_CAPTURE: begin
				cmd.lap_init = 1'b1;
				cmd.rd_sel = SEL_XP;
				cnt_d = '0;
				case (status.req)
					REQ_VEL:   state_d = ST_GATHER;
					REQ_FIELD: state_d = ST_FMUL;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_GATHER: begin
				// one neighbor read per beat, damping product overlapped
				cmd.lap_add = 1'b1;
				cnt_d = cnt_q + 3'd1;
				case (cnt_q)
					3'd0: begin
						cmd.rd_sel = SEL_XM;
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_DAMP_V;
					end
					3'd1: begin
						cmd.rd_sel = SEL_YP;
						cmd.acc_op = ACC_LOAD;
					end
					3'd2: begin
						cmd.rd_sel = SEL_YM;
						cmd.inner_op = INNER_NEG;
					end
					3'd3: cmd.rd_sel = SEL_ZP;
					3'd4: cmd.rd_sel = SEL_ZM;
					default: begin
						cnt_d = '0;
						state_d = ST_LAPMUL;
					end
				endcase
			end
			ST_LAPMUL: begin
				cnt_d = cnt_q + 3'd1;
				case (cnt_q)
					3'd0: begin
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_LAP_LO;
					end
					3'd1: begin
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_LAP_HI;
						cmd.acc_op = ACC_LOAD;
					end
					3'd2: cmd.acc_op = ACC_HI;
					default: begin
						cmd.inner_op = INNER_ADD;
						cnt_d = '0;
						state_d = ST_STEPMUL;
					end
				endcase
			end
			ST_STEPMUL: begin
				cnt_d = cnt_q + 3'd1;
				case (cnt_q)
					3'd0: begin
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_STEP_LO;
					end
					3'd1: begin
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_STEP_HI;
						cmd.acc_op = ACC_LOAD;
					end
					default: begin
						cmd.acc_op = ACC_HI;
						cnt_d = '0;
						state_d = ST_FIN;
					end
				endcase
			end
			ST_FMUL: begin
				cnt_d = cnt_q + 3'd1;
				case (cnt_q)
					3'd0: begin
						cmd.mul_en = 1'b1;
						cmd.mul_sel = MUL_STEP_V;
					end
					default: begin
						cmd.acc_op = ACC_LOAD;
						cnt_d = '0;
						state_d = ST_FIN;
					end
				endcase
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

[src/ldwl_dp.sv]
// datapath: lattice memories, laplacian accumulator, shared 32x33 multiplier,
// accumulator, saturation and the result register
// depends on ldwl_pkg
module ldwl_dp #(
	parameter int GRID_SIDE = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ldwl_pkg::cmd_t                       cmd,
	output ldwl_pkg::status_t                    status,
	input  logic [ldwl_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [1:0]                           s_tuser,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [ldwl_pkg::VAL_W-1:0]           cfg_data,
	output logic [ldwl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tuser
);
	import ldwl_pkg::*;

	localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int ADW = $clog2(DEPTH);
	localparam int PW_LAP = VAL_W + LAP_W;
	localparam int IW_RAW = PW_LAP - FRAC_BITS + 1;
	localparam int IW = (IW_RAW > DIG_W + 1) ? IW_RAW : DIG_W + 1;
	localparam int AW = (VAL_W + IW > PW_LAP) ? VAL_W + IW : PW_LAP;
	localparam int SHW = AW - FRAC_BITS;
	localparam int SUMW = ((SHW > VAL_W) ? SHW : VAL_W) + 1;
	localparam int PRW = VAL_W + DIG_W + 1;

	function automatic logic [CW-1:0] wrap(input logic [COORD_W-1:0] c);
		logic [8:0] v;
		v = 9'(c);
		for (int i = 0; i < 8; i++) begin
			if (v >= 9'(GRID_SIDE)) v = v - 9'(GRID_SIDE);
		end
		return v[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] inc(input logic [CW-1:0] c);
		return (c == CW'(GRID_SIDE - 1)) ? '0 : c + 1'b1;
	endfunction

	function automatic logic [CW-1:0] dec(input logic [CW-1:0] c);
		return (c == '0) ? CW'(GRID_SIDE - 1) : c - 1'b1;
	endfunction

	function automatic logic [ADW-1:0] site(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		return ADW'((ADW'(x) * ADW'(GRID_SIDE) + ADW'(y)) * ADW'(GRID_SIDE) + ADW'(z));
	endfunction

	// configuration
	logic signed [VAL_W-1:0] step_q, lap_coef_q, damp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			lap_coef_q <= '0;
			damp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP: step_q <= $signed(cfg_data);
				CFG_LAP:  lap_coef_q <= $signed(cfg_data);
				CFG_DAMP: damp_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// request
	req_t req_q;
	logic [CW-1:0] x_q, y_q, z_q;
	logic [VAL_W-1:0] ld_f_q, ld_v_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_t'(s_tuser);
			x_q <= wrap(s_tdata[X_LSB +: COORD_W]);
			y_q <= wrap(s_tdata[Y_LSB +: COORD_W]);
			z_q <= wrap(s_tdata[Z_LSB +: COORD_W]);
			ld_f_q <= s_tdata[LF_LSB +: VAL_W];
			ld_v_q <= s_tdata[LV_LSB +: VAL_W];
		end
	end

	assign status.req = req_q;

	// read address
	logic [CW-1:0] ax, ay, az;
	logic [ADW-1:0] rd_addr, c_addr;

	always_comb begin
		ax = x_q;
		ay = y_q;
		az = z_q;
		case (cmd.rd_sel)
			SEL_XP:  ax = inc(x_q);
			SEL_XM:  ax = dec(x_q);
			SEL_YP:  ay = inc(y_q);
			SEL_YM:  ay = dec(y_q);
			SEL_ZP:  az = inc(z_q);
			SEL_ZM:  az = dec(z_q);
			default: ;
		endcase
	end

	assign rd_addr = site(ax, ay, az);
	assign c_addr = site(x_q, y_q, z_q);

	// lattice memories
	logic [VAL_W-1:0] fmem [DEPTH];
	logic [VAL_W-1:0] vmem [DEPTH];
	logic [VAL_W-1:0] rd_f_q, rd_v_q;
	logic f_we, v_we;
	logic [VAL_W-1:0] f_wd, v_wd;

	always_ff @(posedge clk) begin
		if (f_we) fmem[c_addr] <= f_wd;
		rd_f_q <= fmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (v_we) vmem[c_addr] <= v_wd;
		rd_v_q <= vmem[rd_addr];
	end

	// center capture and laplacian
	logic signed [VAL_W-1:0] cen_f_q, vel_q;
	logic signed [LAP_W-1:0] lap_q, c_ext, six_c;

	assign c_ext = LAP_W'($signed(rd_f_q));
	assign six_c = (c_ext <<< 2) + (c_ext <<< 1);

	always_ff @(posedge clk) begin
		if (cmd.lap_init) begin
			lap_q <= -six_c;
			cen_f_q <= $signed(rd_f_q);
			vel_q <= $signed(rd_v_q);
		end else if (cmd.lap_add) begin
			lap_q <= lap_q + c_ext;
		end
	end

	// shared multiplier and accumulator
	logic signed [VAL_W-1:0] a_op;
	logic signed [DIG_W:0] b_op;
	logic signed [PRW-1:0] prod_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [SHW-1:0] sh;
	logic signed [IW-1:0] inner_q;

	always_comb begin
		a_op = step_q;
		b_op = (DIG_W + 1)'(vel_q);
		case (cmd.mul_sel)
			MUL_LAP_LO: begin
				a_op = lap_coef_q;
				b_op = $signed({1'b0, lap_q[DIG_W-1:0]});
			end
			MUL_LAP_HI: begin
				a_op = lap_coef_q;
				b_op = (DIG_W + 1)'($signed(lap_q[LAP_W-1:DIG_W]));
			end
			MUL_DAMP_V: begin
				a_op = damp_q;
				b_op = (DIG_W + 1)'(vel_q);
			end
			MUL_STEP_LO: begin
				a_op = step_q;
				b_op = $signed({1'b0, inner_q[DIG_W-1:0]});
			end
			MUL_STEP_HI: begin
				a_op = step_q;
				b_op = (DIG_W + 1)'($signed(inner_q[IW-1:DIG_W]));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_s1 <= a_op * b_op;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= AW'(prod_s1);
			ACC_HI:   acc_q <= acc_q + (AW'(prod_s1) <<< DIG_W);
			default: ;
		endcase
		case (cmd.inner_op)
			INNER_NEG: inner_q <= -IW'(sh);
			INNER_ADD: inner_q <= inner_q + IW'(sh);
			default: ;
		endcase
	end

	assign sh = SHW'(acc_q >>> FRAC_BITS);

	// saturating update and result
	logic signed [VAL_W-1:0] base, clip, res_f, res_v;
	logic signed [SUMW-1:0] sum;
	logic sat_hi, sat_lo, res_sat;
	logic signed [VAL_W-1:0] out_f_q, out_v_q;
	logic out_sat_q;

	always_comb begin
		base = (req_q == REQ_VEL) ? vel_q : cen_f_q;
		sum = SUMW'(base) + SUMW'(sh);
		sat_hi = sum > SUMW'(I32_MAX);
		sat_lo = sum < SUMW'(I32_MIN);
		clip = sat_hi ? I32_MAX : (sat_lo ? I32_MIN : VAL_W'(sum));
		res_f = cen_f_q;
		res_v = vel_q;
		res_sat = 1'b0;
		f_we = 1'b0;
		v_we = 1'b0;
		case (req_q)
			REQ_LOAD: begin
				res_f = $signed(ld_f_q);
				res_v = $signed(ld_v_q);
				f_we = cmd.fin;
				v_we = cmd.fin;
			end
			REQ_VEL: begin
				res_v = clip;
				res_sat = sat_hi | sat_lo;
				v_we = cmd.fin;
			end
			REQ_FIELD: begin
				res_f = clip;
				res_sat = sat_hi | sat_lo;
				f_we = cmd.fin;
			end
			default: ;
		endcase
		f_wd = res_f;
		v_wd = res_v;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_f_q <= res_f;
			out_v_q <= res_v;
			out_sat_q <= res_sat;
		end
	end

	assign m_tdata = {out_v_q, out_f_q};
	assign m_tuser = out_sat_q;

endmodule

[src/lattice_damped_wave_leapfrog_top.sv]
// damped wave leapfrog lattice, top level: controller plus datapath
// one item in flight; load and read go from the center read to the result, field update
// adds one multiply; velocity update: seven reads through the single field memory read
// port, one damping pass overlapped, then four through the one shared 32x33 multiplier
// a new item is taken the cycle after its result is registered, even if not yet drained
// arst_n clears control state and coefficients; lattice memories hold nothing until loaded
module lattice_damped_wave_leapfrog_top #(
	parameter int GRID_SIDE = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// site_x, site_y, site_z, load_field, load_velocity, zero pad
	input  logic [ldwl_pkg::IN_TDATA_W-1:0]      s_tdata,
	// req_type
	input  logic [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// site_field, site_velocity
	output logic [ldwl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// saturated
	output logic                                 m_tuser,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [ldwl_pkg::VAL_W-1:0]           cfg_data
);
	import ldwl_pkg::*;

	cmd_t cmd;
	status_t status;

	ldwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ldwl_dp #(
		.GRID_SIDE (GRID_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result raised right after accept");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised without an item in flight");

endmodule
